@@ src/agf_pkg.sv @@
// Shared constants, types and helper functions of the anagram group finder.
package agf_pkg;

   localparam int MAX_STRINGS  = 16;
   localparam int MAX_LENGTH   = 127;
   localparam int ALPHABET_LEN = 26;
   localparam int KEPT_STRINGS = (MAX_STRINGS < 16) ? MAX_STRINGS : 16;
   localparam int IDX_W        = $clog2(KEPT_STRINGS);
   localparam int PTR_W        = $clog2(KEPT_STRINGS + 1);
   localparam int POS_W        = $clog2(MAX_LENGTH + 1);
   localparam int CNT_W        = 7;
   localparam int LET_W        = $clog2(ALPHABET_LEN);
   localparam int MIDX_W       = 4;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   typedef logic [ALPHABET_LEN-1:0][CNT_W-1:0] hist_type;
   typedef logic [KEPT_STRINGS-1:0]        str_mask_type;
   typedef logic [IDX_W-1:0]               str_idx_type;
   typedef logic [PTR_W-1:0]               str_ptr_type;

   typedef struct packed {
      logic             hit;
      logic [LET_W-1:0] idx;
   } letter_type;

   typedef struct packed {
      logic load_en;
      logic cmp_init;
      logic cmp_run;
      logic set_clear;
      logic emit_en;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pair_ok;
      logic emit_done;
   } dp_sts_type;

   // lowest set bit of a string mask
   function automatic str_idx_type lowest_bit(input str_mask_type m);
      str_idx_type idx;
      idx = '0;
      for (int k = KEPT_STRINGS - 1; k >= 0; k--) begin
         if (m[k]) begin
            idx = str_idx_type'(k);
         end
      end
      return idx;
   endfunction

   function automatic str_mask_type one_hot(input str_idx_type idx);
      return str_mask_type'(1) << idx;
   endfunction

   // case-folded letter index, hit low for anything that is not a letter
   function automatic letter_type decode_letter(input logic [7:0] ch);
      letter_type res;
      logic [7:0] diff;
      res  = '0;
      diff = '0;
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
         diff    = ch - CHAR_UPPER_A;
         res.hit = 1'b1;
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         diff    = ch - CHAR_LOWER_A;
         res.hit = 1'b1;
      end
      res.idx = diff[LET_W-1:0];
      return res;
   endfunction

endpackage

@@ src/anagram_group_finder_core.sv @@
// Top level of the anagram group finder: sequencer plus datapath.
//
// Input channel (req_): one word per byte of a string. req_end_of_string
// closes the current string, req_end_of_set closes the last string and starts
// the grouping. The byte on a closing word still counts. Letters are case
// folded and counted per string, counts stop at 127, bytes past 127 in one
// string and strings past 16 are dropped.
// Result channel (rsp_): one word per group member, groups in order of their
// lowest index, members ascending; group_last marks a group's end, set_last
// the final word of the set. With no group a single word with member_valid
// low and set_last high is sent.
// Throughput: one input word per cycle while loading (histogram
// read-modify-write with forwarding). After end of set the block compares one
// histogram pair per cycle through the two-port row store, then sends one
// result word per cycle unless rsp_ready stalls.
// The output register holds a word while the receiver stalls; emission waits.
// req_ready is low from end of set until the last word is registered.
// Reset: synchronous, clears the string pointer, byte count and row valid bits;
// no clearing pass is needed and a word may be taken in the first cycle after reset.
module anagram_group_finder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_string,
   input  logic       req_end_of_set,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_member_index,
   output logic       rsp_member_valid,
   output logic       rsp_group_last,
   output logic       rsp_set_last
);
   import agf_pkg::*;

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   agf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_end_of_set (req_end_of_set),
      .sts            (sts),
      .cmd            (cmd)
   );

   agf_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_valid         (req_valid),
      .req_char_code     (req_char_code),
      .req_end_of_string (req_end_of_string),
      .req_end_of_set    (req_end_of_set),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_member_index  (rsp_member_index),
      .rsp_member_valid  (rsp_member_valid),
      .rsp_group_last    (rsp_group_last),
      .rsp_set_last      (rsp_set_last)
   );

   // loading only in the load phase
   assign req_ready = cmd.load_en;

endmodule

@@ src/agf_ctrl.sv @@
// Sequencer of the anagram group finder: load, compare, emit.
module agf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_end_of_set,
   input  agf_pkg::dp_sts_type  sts,
   output agf_pkg::ctrl_cmd_type cmd
);
   import agf_pkg::*;

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_FLUSH = 3'd1;
   localparam logic [2:0] ST_CMP   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_PREP  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load_en = 1'b1;
            if (req_valid && req_end_of_set) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // last histogram write lands this cycle
            cmd.cmp_init = 1'b1;
            state_in     = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp_run = 1'b1;
            if (!sts.pair_ok) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.set_clear = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_en = 1'b1;
            if (sts.emit_done) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/agf_datapath.sv @@
// Histogram store, pairwise compare and group emission of the anagram group finder.
module agf_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  agf_pkg::ctrl_cmd_type cmd,
   output agf_pkg::dp_sts_type   sts,
   input  logic                  req_valid,
   input  logic [7:0]            req_char_code,
   input  logic                  req_end_of_string,
   input  logic                  req_end_of_set,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [3:0]            rsp_member_index,
   output logic                  rsp_member_valid,
   output logic                  rsp_group_last,
   output logic                  rsp_set_last
);
   import agf_pkg::*;

   // ---------------- load side ----------------
   logic        accept, in_range, take, closes;
   letter_type  let_dec;
   str_idx_type sp_idx;

   str_ptr_type       sp_ff, sp_in;
   logic [POS_W-1:0]  cpos_ff, cpos_in;
   str_mask_type      row_valid_ff, row_valid_in;

   logic                s2_v_ff;
   str_idx_type         s2_row_ff;
   logic [LET_W-1:0]    s2_let_ff;
   logic                s2_rowv_ff, s2_fwd_ff;
   hist_type            wr_row_ff;
   hist_type            base_row, new_row;

   hist_type    mem [KEPT_STRINGS];
   hist_type    rda_ff, rdb_ff;
   str_idx_type addr_a;

   assign accept  = cmd.load_en & req_valid;
   assign sp_idx  = sp_ff[IDX_W-1:0];
   assign let_dec = decode_letter(req_char_code);

   always_comb begin
      in_range = sp_ff < PTR_W'(KEPT_STRINGS);
      take     = accept && (req_char_code != 8'd0) && in_range
                 && (cpos_ff < POS_W'(MAX_LENGTH));
      closes   = req_end_of_string | req_end_of_set;
      sp_in    = sp_ff;
      cpos_in  = cpos_ff;
      if (cmd.set_clear) begin
         sp_in   = '0;
         cpos_in = '0;
      end else if (accept) begin
         if (take) begin
            cpos_in = cpos_ff + POS_W'(1);
         end
         if (closes) begin
            cpos_in = '0;
            if (in_range) begin
               sp_in = sp_ff + PTR_W'(1);
            end
         end
      end
   end

   // read-modify-write: an invalid row reads as zero, a back-to-back hit forwards
   always_comb begin
      if (s2_fwd_ff) begin
         base_row = wr_row_ff;
      end else if (s2_rowv_ff) begin
         base_row = rda_ff;
      end else begin
         base_row = '0;
      end
      new_row = base_row;
      if (base_row[s2_let_ff] != COUNT_MAX) begin
         new_row[s2_let_ff] = base_row[s2_let_ff] + CNT_W'(1);
      end
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      if (cmd.set_clear) begin
         row_valid_in = '0;
      end else if (s2_v_ff) begin
         row_valid_in = row_valid_ff | one_hot(s2_row_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         cpos_ff      <= '0;
         row_valid_ff <= '0;
         s2_v_ff      <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         cpos_ff      <= cpos_in;
         row_valid_ff <= row_valid_in;
         s2_v_ff      <= take && let_dec.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_row_ff  <= sp_idx;
         s2_let_ff  <= let_dec.idx;
         s2_rowv_ff <= row_valid_ff[sp_idx];
         s2_fwd_ff  <= s2_v_ff && (s2_row_ff == sp_idx);
      end
      if (s2_v_ff) begin
         wr_row_ff <= new_row;
      end
   end

   // ---------------- pair walk ----------------
   str_ptr_type i_ff, j_ff;
   logic        pair_ok, issue;
   logic        cmp_v_ff, cmp_va_ff, cmp_vb_ff;
   str_idx_type cmp_i_ff, cmp_j_ff;
   hist_type    row_a, row_b;
   logic        match;

   str_mask_type eq_row_ff [KEPT_STRINGS];
   str_mask_type has_later_ff, has_earlier_ff;

   assign pair_ok = j_ff < sp_ff;
   assign issue   = cmd.cmp_run && pair_ok;
   assign addr_a  = cmd.cmp_run ? i_ff[IDX_W-1:0] : sp_idx;

   always_ff @(posedge clock) begin
      if (s2_v_ff) begin
         mem[s2_row_ff] <= new_row;
      end
      rda_ff <= mem[addr_a];
      rdb_ff <= mem[j_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp_init) begin
         i_ff <= '0;
         j_ff <= PTR_W'(1);
      end else if (issue) begin
         if (j_ff + PTR_W'(1) < sp_ff) begin
            j_ff <= j_ff + PTR_W'(1);
         end else begin
            i_ff <= i_ff + PTR_W'(1);
            j_ff <= i_ff + PTR_W'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_v_ff <= 1'b0;
      end else begin
         cmp_v_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         cmp_i_ff  <= i_ff[IDX_W-1:0];
         cmp_j_ff  <= j_ff[IDX_W-1:0];
         cmp_va_ff <= row_valid_ff[i_ff[IDX_W-1:0]];
         cmp_vb_ff <= row_valid_ff[j_ff[IDX_W-1:0]];
      end
   end

   assign row_a = cmp_va_ff ? rda_ff : '0;
   assign row_b = cmp_vb_ff ? rdb_ff : '0;
   assign match = cmp_v_ff && (row_a == row_b);

   always_ff @(posedge clock) begin
      if (cmd.cmp_init) begin
         for (int k = 0; k < KEPT_STRINGS; k++) begin
            eq_row_ff[k] <= '0;
         end
         has_later_ff   <= '0;
         has_earlier_ff <= '0;
      end else if (match) begin
         eq_row_ff[cmp_i_ff][cmp_j_ff] <= 1'b1;
         has_later_ff[cmp_i_ff]        <= 1'b1;
         has_earlier_ff[cmp_j_ff]      <= 1'b1;
      end
   end

   // ---------------- emission ----------------
   // equal histograms are transitive: a leader's row lists its whole group
   str_mask_type leaders, rem_ff, left_ff, rem_rest;
   logic         none_ff, step, glast, slast, rsp_valid_ff;
   str_idx_type  first_lead, next_lead, member;

   logic [3:0] rsp_index_ff;
   logic       rsp_mvalid_ff, rsp_glast_ff, rsp_slast_ff;

   assign leaders    = has_later_ff & ~has_earlier_ff;
   assign first_lead = lowest_bit(leaders);
   assign next_lead  = lowest_bit(left_ff);
   assign member     = lowest_bit(rem_ff);
   assign rem_rest   = rem_ff & ~one_hot(member);
   assign glast      = (rem_rest == '0);
   assign slast      = none_ff || (glast && (left_ff == '0));
   assign step       = cmd.emit_en && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (cmd.set_clear) begin
         rem_ff  <= eq_row_ff[first_lead] | one_hot(first_lead);
         left_ff <= leaders & ~one_hot(first_lead);
         none_ff <= (leaders == '0);
      end else if (step && !none_ff) begin
         if (glast && (left_ff != '0)) begin
            rem_ff  <= eq_row_ff[next_lead] | one_hot(next_lead);
            left_ff <= left_ff & ~one_hot(next_lead);
         end else begin
            rem_ff <= rem_rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_index_ff  <= none_ff ? 4'd0 : MIDX_W'(member);
         rsp_mvalid_ff <= !none_ff;
         rsp_glast_ff  <= !none_ff && glast;
         rsp_slast_ff  <= slast;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_member_index = rsp_index_ff;
   assign rsp_member_valid = rsp_mvalid_ff;
   assign rsp_group_last   = rsp_glast_ff;
   assign rsp_set_last     = rsp_slast_ff;

   assign sts.pair_ok   = pair_ok;
   assign sts.emit_done = step && slast;

endmodule

@@ src/agf_checker.sv @@
// Port-level checks of the anagram group finder, bound to the top level.
module agf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_char_code,
   input logic       req_end_of_string,
   input logic       req_end_of_set,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_member_index,
   input logic       rsp_member_valid,
   input logic       rsp_group_last,
   input logic       rsp_set_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_member_index)
         && $stable(rsp_set_last) && $stable(rsp_group_last))
      else $error("result word changed while stalled");

   a_empty_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_member_valid |-> rsp_set_last && !rsp_group_last
         && rsp_member_index == 4'd0)
      else $error("empty result word malformed");

   a_final_closes_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_set_last && rsp_member_valid |-> rsp_group_last)
      else $error("set ended inside a group");

   a_busy_after_set: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_set |=> !req_ready)
      else $error("input taken right after end of set");

   a_no_result_while_loading: assert property (@(posedge clock) disable iff (reset)
      req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared during loading");

endmodule

bind anagram_group_finder_core agf_checker u_agf_checker (.*);

@@ sim/agf_group_checker.sv @@
// Checker for the anagram group finder: predicts the group words and compares them.
module agf_group_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_string,
   input  logic       req_end_of_set,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [3:0] rsp_member_index,
   input  logic       rsp_member_valid,
   input  logic       rsp_group_last,
   input  logic       rsp_set_last,
   output int         fail_count,
   output int         members_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import agf_pkg::*;

   typedef struct packed {
      logic [MIDX_W-1:0] index;
      logic              valid;
      logic              group_last;
      logic              set_last;
   } member_word_type;

   hist_type        string_hist [KEPT_STRINGS];
   int              strings_closed;
   int              bytes_taken;
   int              errs;
   member_word_type members_q [$];

   initial begin
      fail_count  = 0;
      members_due = 0;
      errs        = 0;
   end

   always @(posedge clock) begin : watch
      member_word_type got;
      member_word_type want;
      member_word_type found [KEPT_STRINGS];
      str_mask_type    taken;
      logic [7:0]      ch;
      int              n;
      int              letter;
      logic            opened;
      if (reset) begin
         for (int s = 0; s < KEPT_STRINGS; s++) string_hist[s] = '0;
         strings_closed = 0;
         bytes_taken    = 0;
         members_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_member_index, rsp_member_valid, rsp_group_last, rsp_set_last};
            if (members_q.size() == 0) begin
               $error("result word with nothing expected: index %0d valid %0b",
                      got.index, got.valid);
               errs++;
            end else begin
               want = members_q.pop_front();
               if (got.index !== want.index) begin
                  $error("member_index: expected %0d, got %0d", want.index, got.index);
                  errs++;
               end
               if (got.valid !== want.valid) begin
                  $error("member_valid: expected %0b, got %0b", want.valid, got.valid);
                  errs++;
               end
               if (got.group_last !== want.group_last) begin
                  $error("group_last: expected %0b, got %0b",
                         want.group_last, got.group_last);
                  errs++;
               end
               if (got.set_last !== want.set_last) begin
                  $error("set_last: expected %0b, got %0b", want.set_last, got.set_last);
                  errs++;
               end
            end
         end

         if (req_valid && req_ready) begin
            ch = req_char_code;
            // zero bytes never count, nor bytes past the length limit
            if (ch != 8'h00 && strings_closed < KEPT_STRINGS && bytes_taken < MAX_LENGTH) begin
               bytes_taken++;
               letter = -1;
               if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
                  letter = int'(ch - CHAR_UPPER_A);
               end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
                  letter = int'(ch - CHAR_LOWER_A);
               end
               if (letter >= 0 && string_hist[strings_closed][letter] != COUNT_MAX) begin
                  string_hist[strings_closed][letter] += 1;
               end
            end
            if (req_end_of_string || req_end_of_set) begin
               if (strings_closed < KEPT_STRINGS) strings_closed++;
               bytes_taken = 0;
            end
            if (req_end_of_set) begin
               taken = '0;
               n     = 0;
               for (int i = 0; i < strings_closed; i++) begin
                  if (!taken[i]) begin
                     opened = 1'b0;
                     for (int j = i + 1; j < strings_closed; j++) begin
                        if (!taken[j] && string_hist[i] == string_hist[j]) begin
                           if (!opened) begin
                              found[n] = {MIDX_W'(i), 1'b1, 1'b0, 1'b0};
                              n++;
                              taken[i] = 1'b1;
                              opened   = 1'b1;
                           end
                           found[n] = {MIDX_W'(j), 1'b1, 1'b0, 1'b0};
                           n++;
                           taken[j] = 1'b1;
                        end
                     end
                     if (opened) found[n-1].group_last = 1'b1;
                  end
               end
               if (n == 0) begin
                  members_q.push_back({MIDX_W'(0), 1'b0, 1'b0, 1'b1});
               end else begin
                  found[n-1].set_last = 1'b1;
                  for (int k = 0; k < n; k++) members_q.push_back(found[k]);
               end
               for (int s = 0; s < KEPT_STRINGS; s++) string_hist[s] = '0;
               strings_closed = 0;
               bytes_taken    = 0;
            end
         end
      end
      fail_count  <= errs;
      members_due <= members_q.size();
   end

endmodule

@@ sim/anagram_group_finder_core_test.sv @@
// Testbench top of the anagram group finder: stimulus, receiver and verdict.
module anagram_group_finder_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import agf_pkg::*;

   localparam int STIM_WORDS  = 400;  // directed plus random words
   localparam int SHAPE_SLOTS = 24;
   localparam int SHAPE_LEN   = 144;
   localparam int LONG_HOLD   = 600;  // receiver hold-off, in cycles

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_code = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       req_end_of_set = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_member_index;
   logic       rsp_member_valid;
   logic       rsp_group_last;
   logic       rsp_set_last;
   int         fail_count;
   int         members_due;

   // letter shapes of the strings in the current set, lower case only
   logic [7:0] shape_chars [SHAPE_SLOTS][SHAPE_LEN];
   int         shape_len   [SHAPE_SLOTS];

   bit         tx_burst    = 1'b0;  // sender offers back to back
   bit         rx_hold_req = 1'b0;  // asks the receiver for one long hold-off
   int         words_sent  = 0;

   anagram_group_finder_core u_top (.*);
   agf_group_checker         u_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Safety net: the slowest legal run is well under a tenth of this.
   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Any byte that is not a letter: these must leave the histogram alone.
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while ((b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
                 (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z));
      return b;
   endfunction

   // Offer one word and hold it until it is taken. A zero gap keeps valid
   // high straight into the next word, so valid is only ever written once
   // per edge.
   task automatic send_word(input logic [7:0] ch, input logic eos, input logic eoset);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_char_code     <= ch;
      req_end_of_string <= eos;
      req_end_of_set    <= eoset;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // Literal text, the closing flags ride on its last byte.
   task automatic send_text(input string s, input logic eos, input logic eoset);
      for (int p = 0; p < s.len() - 1; p++) send_word(s[p], 1'b0, 1'b0);
      send_word(s[s.len()-1], eos, eoset);
   endtask

   // One string from shape slot k: random case, stray non-letters mixed in,
   // and the closing word carries either the last byte or a stray one.
   task automatic send_string(input int k, input bit closes_set);
      logic [7:0] bytes_q [$];
      logic [7:0] c;
      logic [7:0] tail;
      logic       eos;
      for (int p = 0; p < shape_len[k]; p++) begin
         if ($urandom_range(0, 5) == 0) bytes_q.push_back(noise_byte());
         c = shape_chars[k][p];
         if ($urandom_range(0, 1)) c = c - (CHAR_LOWER_A - CHAR_UPPER_A);
         bytes_q.push_back(c);
      end
      if (bytes_q.size() > 0 && $urandom_range(0, 1)) begin
         tail = bytes_q.pop_back();
      end else begin
         tail = $urandom_range(0, 1) ? 8'h00 : noise_byte();
      end
      foreach (bytes_q[p]) send_word(bytes_q[p], 1'b0, 1'b0);
      // end of set closes the string on its own; end_of_string is optional then
      eos = closes_set ? logic'($urandom_range(0, 1)) : 1'b1;
      send_word(tail, eos, closes_set);
   endtask

   // A well-formed set: each string is either new or an anagram of an earlier
   // one, now and then with one letter changed to make a near miss.
   task automatic send_set(input int n_str, input int min_len, input int max_len,
                           input int alpha);
      int         src;
      int         j;
      logic [7:0] t;
      tx_burst = ($urandom_range(0, 3) == 0);
      for (int m = 0; m < n_str; m++) begin
         if (m > 0 && $urandom_range(0, 1)) begin
            src          = $urandom_range(0, m - 1);
            shape_len[m] = shape_len[src];
            for (int p = 0; p < shape_len[m]; p++) shape_chars[m][p] = shape_chars[src][p];
            for (int p = shape_len[m] - 1; p > 0; p--) begin
               j                  = $urandom_range(0, p);
               t                  = shape_chars[m][p];
               shape_chars[m][p]  = shape_chars[m][j];
               shape_chars[m][j]  = t;
            end
            if (shape_len[m] > 0 && $urandom_range(0, 3) == 0) begin
               shape_chars[m][$urandom_range(0, shape_len[m] - 1)] =
                  CHAR_LOWER_A + 8'($urandom_range(0, 25));
            end
         end else begin
            shape_len[m] = $urandom_range(min_len, max_len);
            for (int p = 0; p < shape_len[m]; p++) begin
               shape_chars[m][p] = CHAR_LOWER_A + 8'($urandom_range(0, alpha - 1));
            end
         end
         send_string(m, m == n_str - 1);
      end
   endtask

   // Broken traffic: random bytes and flags, then a word that ends the set.
   task automatic send_noise();
      tx_burst = ($urandom_range(0, 1) == 0);
      repeat ($urandom_range(4, 12)) begin
         send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 9) == 0);
      end
      send_word(8'($urandom_range(0, 255)), logic'($urandom_range(0, 1)), 1'b1);
   endtask

   // Park the sender, valid low, until every predicted word has been taken.
   // The first edge lets the checker's count catch up with the last
   // accepted word.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (members_due != 0) @(posedge clock);
   endtask

   // Receiver: a fresh stall per word, bursts with no stall, and one long
   // hold-off on request so the block fills and backs up its input.
   initial begin : receiver
      int stall;
      int rx_run;
      rx_run = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rx_hold_req = 1'b0;
         end
         if (rx_run > 0) begin
            stall = 0;
            rx_run--;
         end else begin
            if ($urandom_range(0, 15) == 0) rx_run = $urandom_range(10, 40);
            stall = $urandom_range(0, 19);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid && !rx_hold_req) @(posedge clock);
      end
   end

   initial begin : stimulus
      int set_no;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: a plain anagram pair across case, closing byte counted.
      send_text("Listen", 1'b1, 1'b0);
      send_text("siLenT", 1'b1, 1'b1);
      // No group at all; end of set alone closes the last string.
      send_text("ab", 1'b1, 1'b0);
      send_text("c", 1'b0, 1'b1);
      // Empty strings group together: zero byte, top byte and the bytes just
      // outside both letter ranges; then Z and z fold together.
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hFF, 1'b1, 1'b0);
      send_text("@[`{", 1'b1, 1'b0);
      send_word("Z", 1'b1, 1'b0);
      send_word("z", 1'b1, 1'b1);
      // sender pause: nothing more until the set is fully out
      wait_drained();

      set_no = 0;
      while (words_sent < STIM_WORDS) begin
         if (set_no == 1) begin
            // more strings than the block keeps, short and clash-prone
            send_set($urandom_range(17, 20), 0, 2, 2);
         end else if (set_no == 2) begin
            // two long strings of one letter: length limit and count ceiling
            send_set(2, 128, 132, 1);
         end else if ($urandom_range(0, 4) == 0) begin
            send_noise();
         end else if ($urandom_range(0, 5) == 0) begin
            send_set($urandom_range(9, 16), 0, 4, $urandom_range(1, 4));
         end else begin
            send_set($urandom_range(1, 8), 0, 6, $urandom_range(1, 26));
         end
         if (set_no == 1) begin
            // results stay parked while the long set queues up behind them
            rx_hold_req = 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            wait_drained();
         end
         set_no++;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && members_due == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ anagram_group_finder_core.f @@
src/agf_pkg.sv
src/agf_ctrl.sv
src/agf_datapath.sv
src/anagram_group_finder_core.sv
src/agf_checker.sv
sim/agf_group_checker.sv
sim/anagram_group_finder_core_test.sv
